// ----- hw/rtl/alg_pkg.sv -----
// Shared types and constants for the adjacency list graph engine.
// No dependencies; every other file of the block but alg_ram uses this package.
`default_nettype none
package alg_pkg;

  // Field widths fixed by the request and response formats
  localparam int KIND_W = 3;
  localparam int VERT_W = 4;
  localparam int STAT_W = 2;
  localparam int DEG_W  = 4;
  localparam int EDGE_W = 8;
  localparam int VTOT_W = 5;

  // Default sizing of the graph store
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_DEGREE   = 8;

  // Request kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_ADD_EDGE = 3'd0;
  localparam kind_t KIND_DEL_EDGE = 3'd1;
  localparam kind_t KIND_CONN     = 3'd2;
  localparam kind_t KIND_ADD_VERT = 3'd3;
  localparam kind_t KIND_TRAVERSE = 3'd4;
  localparam kind_t KIND_DEGREE   = 3'd5;

  // Response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_VERTEX    = 2'd1,
    ST_LIST_FULL    = 2'd2,
    ST_VERTEX_LIMIT = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WALK_TOP,
    S_WALK_CHK,
    S_WALK_END,
    S_EMIT
  } state_t;

  // One response
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              connected;
    logic [DEG_W-1:0]  source_degree;
    logic              is_empty;
    logic [EDGE_W-1:0] total_edges;
    logic [VTOT_W-1:0] total_vertices;
    logic [VERT_W-1:0] visited_vertex;
    logic              last;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/alg_if.sv -----
// Request and response channel interfaces of the graph engine.
// Depends on alg_pkg for field widths.
`default_nettype none
interface alg_req_if;
  logic                         valid;
  logic                         ready;
  logic [alg_pkg::KIND_W-1:0]   kind;
  logic [alg_pkg::VERT_W-1:0]   source_vertex;
  logic [alg_pkg::VERT_W-1:0]   target_vertex;

  modport source(output valid, kind, source_vertex, target_vertex, input ready);
  modport sink(input valid, kind, source_vertex, target_vertex, output ready);
endinterface

interface alg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [alg_pkg::STAT_W-1:0]   status;
  logic                         connected;
  logic [alg_pkg::DEG_W-1:0]    source_degree;
  logic                         is_empty;
  logic [alg_pkg::EDGE_W-1:0]   total_edges;
  logic [alg_pkg::VTOT_W-1:0]   total_vertices;
  logic [alg_pkg::VERT_W-1:0]   visited_vertex;
  logic                         last;

  modport source(output valid, status, connected, source_degree, is_empty, total_edges,
                 total_vertices, visited_vertex, last, input ready);
  modport sink(input valid, status, connected, source_degree, is_empty, total_edges,
               total_vertices, visited_vertex, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/alg_ram.sv -----
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module alg_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds when no read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/alg_seq.sv -----
// Sequencer of the graph engine: list lengths, counters, walk stack and the
// scan/shift/walk control around one neighbor RAM. Uses alg_pkg and alg_ram.
`default_nettype none
module alg_seq #(
  parameter int MAX_VERTICES = alg_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = alg_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic [alg_pkg::KIND_W-1:0] kind,
  input  wire logic [alg_pkg::VERT_W-1:0] source_vertex,
  input  wire logic [alg_pkg::VERT_W-1:0] target_vertex,
  input  wire logic                       slot_free,
  output logic                            res_valid,
  output alg_pkg::rsp_t                   res
);
  import alg_pkg::*;

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int LW  = $clog2(MAX_DEGREE + 1);
  localparam int AW  = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int VTW = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_VERTICES * MAX_DEGREE + 1);
  localparam int CW  = VERT_W + 1;
  localparam int NV  = 1 << VERT_W;

  typedef struct packed {
    logic [VERT_W-1:0] v;
    logic [LW-1:0]     idx;
  } frame_t;

  state_t            state, state_next;
  kind_t             kind_q;
  logic [VERT_W-1:0] src_q, dst_q, lv, key, pend;
  status_t           status_q;
  logic              conn_q, pass;
  logic [LW-1:0]     k;
  logic [VTW-1:0]    vt;
  logic [EW-1:0]     edges;
  logic [LW-1:0]     len [MAX_VERTICES];
  logic [NV-1:0]     visited;
  frame_t            stack [MAX_VERTICES];
  logic [VTW-1:0]    depth, dm1;

  logic [IW-1:0]     len_addr;
  logic [LW-1:0]     len_rd;
  logic              src_ok, dst_ok, both_ok, full, k_ge, k1_ge, hit, more, fresh;
  logic [LW:0]       k1;
  frame_t            top;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [VERT_W-1:0] mem_wdata, rdata;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] v, input logic [LW:0] i);
    return AW'(v) * AW'(MAX_DEGREE) + AW'(i);
  endfunction

  alg_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Shared conditions: one length read, presence checks, scan compare
  always_comb begin
    dm1 = depth - VTW'(1);
    top = stack[dm1[IW-1:0]];
    if (state == S_WALK_TOP) begin
      len_addr = top.v[IW-1:0];
    end else if (state == S_SCAN_RD || state == S_SCAN_CHK || state == S_SHIFT_RD ||
                 state == S_SHIFT_WR) begin
      len_addr = lv[IW-1:0];
    end else begin
      len_addr = src_q[IW-1:0];
    end
    len_rd  = len[len_addr];
    src_ok  = {1'b0, src_q} < CW'(vt);
    dst_ok  = {1'b0, dst_q} < CW'(vt);
    both_ok = src_ok && dst_ok;
    full    = len_rd >= LW'(MAX_DEGREE);
    k_ge    = k >= len_rd;
    k1      = {1'b0, k} + (LW+1)'(1);
    k1_ge   = k1 >= {1'b0, len_rd};
    hit     = rdata == key;
    more    = top.idx < len_rd;
    fresh   = !visited[rdata];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (kind_q)
          KIND_DEL_EDGE, KIND_CONN: state_next = both_ok ? S_SCAN_RD : S_EMIT;
          KIND_TRAVERSE:            state_next = src_ok ? S_WALK_TOP : S_EMIT;
          default:                  state_next = S_EMIT;
        endcase
      end
      S_SCAN_RD: begin
        if (!k_ge) begin
          state_next = S_SCAN_CHK;
        end else if (kind_q == KIND_DEL_EDGE && !pass) begin
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SCAN_CHK: begin
        if (!hit) begin
          state_next = S_SCAN_RD;
        end else if (kind_q == KIND_CONN) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (!k1_ge) begin
          state_next = S_SHIFT_WR;
        end else begin
          state_next = pass ? S_EMIT : S_SCAN_RD;
        end
      end
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_WALK_TOP: begin
        if (more) begin
          state_next = S_WALK_CHK;
        end else if (depth == VTW'(1)) begin
          state_next = S_WALK_END;
        end
      end
      S_WALK_CHK: if (!fresh || slot_free) state_next = S_WALK_TOP;
      S_WALK_END: if (slot_free) state_next = S_IDLE;
      S_EMIT:     if (slot_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake, RAM access and response fields
  always_comb begin
    req_ready = state == S_IDLE;
    mem_we    = 1'b0;
    mem_waddr = addr_of(src_q[IW-1:0], {1'b0, len_rd});
    mem_wdata = dst_q;
    mem_re    = 1'b0;
    mem_raddr = addr_of(lv[IW-1:0], {1'b0, k});
    unique case (state)
      S_DECODE:   mem_we = kind_q == KIND_ADD_EDGE && both_ok && !full;
      S_SCAN_RD:  mem_re = !k_ge;
      S_SHIFT_RD: begin
        mem_re    = !k1_ge;
        mem_raddr = addr_of(lv[IW-1:0], k1);
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(lv[IW-1:0], {1'b0, k});
        mem_wdata = rdata;
      end
      S_WALK_TOP: begin
        mem_re    = more;
        mem_raddr = addr_of(top.v[IW-1:0], {1'b0, top.idx});
      end
      default: ;
    endcase

    res_valid          = state == S_EMIT || state == S_WALK_END ||
                         (state == S_WALK_CHK && fresh);
    res.status         = (state == S_EMIT) ? status_q : ST_OK;
    res.connected      = (state == S_EMIT) && conn_q;
    res.source_degree  = src_ok ? DEG_W'(len_rd) : '0;
    res.is_empty       = src_ok && (len_rd == '0);
    res.total_edges    = EDGE_W'(edges);
    res.total_vertices = VTOT_W'(vt);
    res.visited_vertex = (state == S_EMIT) ? '0 : pend;
    res.last           = state != S_WALK_CHK;
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vt      <= '0;
      edges   <= '0;
      visited <= '0;
      depth   <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        len[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_q   <= kind;
            src_q    <= source_vertex;
            dst_q    <= target_vertex;
            conn_q   <= 1'b0;
            status_q <= ST_OK;
          end
        end
        S_DECODE: begin
          unique case (kind_q)
            KIND_ADD_EDGE: begin
              if (!both_ok) begin
                status_q <= ST_NO_VERTEX;
              end else if (full) begin
                status_q <= ST_LIST_FULL;
              end else begin
                len[len_addr] <= len_rd + LW'(1);
                edges         <= edges + EW'(1);
              end
            end
            KIND_DEL_EDGE, KIND_CONN: begin
              if (!both_ok) begin
                status_q <= ST_NO_VERTEX;
              end else begin
                lv   <= src_q;
                key  <= dst_q;
                k    <= '0;
                pass <= 1'b0;
              end
            end
            KIND_ADD_VERT: begin
              if (vt >= VTW'(MAX_VERTICES)) begin
                status_q <= ST_VERTEX_LIMIT;
              end else begin
                len[vt[IW-1:0]] <= '0;
                vt              <= vt + VTW'(1);
              end
            end
            KIND_TRAVERSE: begin
              if (!src_ok) begin
                status_q <= ST_NO_VERTEX;
              end else begin
                visited  <= NV'(1) << src_q;
                stack[0] <= '{v: src_q, idx: '0};
                depth    <= VTW'(1);
                pend     <= src_q;
              end
            end
            KIND_DEGREE: begin
              if (!src_ok) status_q <= ST_NO_VERTEX;
            end
            default: ;
          endcase
        end
        S_SCAN_RD: begin
          // Nothing found in the first list: move on to the reverse list
          if (k_ge && kind_q == KIND_DEL_EDGE && !pass) begin
            pass <= 1'b1;
            lv   <= dst_q;
            key  <= src_q;
            k    <= '0;
          end
        end
        S_SCAN_CHK: begin
          if (hit) begin
            if (kind_q == KIND_CONN) conn_q <= 1'b1;
          end else begin
            k <= k + LW'(1);
          end
        end
        S_SHIFT_RD: begin
          // Tail closed up: drop one entry, then start the reverse list
          if (k1_ge) begin
            len[len_addr] <= len_rd - LW'(1);
            edges         <= edges - EW'(1);
            if (!pass) begin
              pass <= 1'b1;
              lv   <= dst_q;
              key  <= src_q;
              k    <= '0;
            end
          end
        end
        S_SHIFT_WR: k <= k + LW'(1);
        S_WALK_TOP: begin
          if (more) begin
            stack[dm1[IW-1:0]].idx <= top.idx + LW'(1);
          end else begin
            depth <= dm1;
          end
        end
        S_WALK_CHK: begin
          // Push an unvisited neighbor once its predecessor has been sent
          if (fresh && slot_free) begin
            visited[rdata]         <= 1'b1;
            stack[depth[IW-1:0]]   <= '{v: rdata, idx: '0};
            depth                  <= depth + VTW'(1);
            pend                   <= rdata;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/adjacency_list_graph_engine_unit.sv -----
// Adjacency list graph engine: a directed graph of up to MAX_VERTICES vertices with
// ordered neighbor lists of up to MAX_DEGREE entries held in one RAM. A request is taken
// only while the engine is idle. Add edge, add vertex, degree query and rejected requests
// go from decode through the emit state to the response register. Connected query and
// delete read and compare a list entry by entry, and a delete moves up each entry behind
// the removed one, done for the source list and then the target list. A traversal reads
// each stored neighbor of the vertex on top of the walk stack, pops finished ones, and
// sends one response per reached vertex in preorder, the final one marked last. All
// list work is bounded by the single RAM read port, one entry per access. Depends on
// alg_pkg, alg_if, alg_ram and alg_seq.
`default_nettype none
module adjacency_list_graph_engine_unit #(
  parameter int MAX_VERTICES = alg_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = alg_pkg::DEF_MAX_DEGREE
) (
  input wire logic clk,
  input wire logic rst,
  alg_req_if.sink  req,
  alg_rsp_if.source rsp
);
  import alg_pkg::*;

  logic slot_free, res_valid, out_valid;
  rsp_t res, out_q;

  alg_seq #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .kind          (req.kind),
    .source_vertex (req.source_vertex),
    .target_vertex (req.target_vertex),
    .slot_free     (slot_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Response register: load when empty or being drained
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_q.status;
  assign rsp.connected      = out_q.connected;
  assign rsp.source_degree  = out_q.source_degree;
  assign rsp.is_empty       = out_q.is_empty;
  assign rsp.total_edges    = out_q.total_edges;
  assign rsp.total_vertices = out_q.total_vertices;
  assign rsp.visited_vertex = out_q.visited_vertex;
  assign rsp.last           = out_q.last;
endmodule
`default_nettype wire

// ----- hw/rtl/alg_chk.sv -----
// Port level checks of the graph engine, bound to the top level.
// Depends on alg_pkg.
`default_nettype none
module alg_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_valid,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [alg_pkg::STAT_W-1:0] rsp_status,
  input wire logic [alg_pkg::VERT_W-1:0] rsp_visited,
  input wire logic                       rsp_last
);
  import alg_pkg::*;

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visited) && $stable(rsp_last))
    else $error("response changed while stalled");

  // Drop ready after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("engine ready right after a request");

  // Only traversal results are not last, and those are always ok
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ST_OK)
    else $error("non-final response with error status");

  // A reported vertex comes only with ok status
  a_visit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_visited != '0 |-> rsp_status == ST_OK)
    else $error("visited vertex on failed request");
endmodule

bind adjacency_list_graph_engine_unit alg_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_visited (rsp.visited_vertex),
  .rsp_last    (rsp.last)
);
`default_nettype wire
